// ----- hdl/pmsp_pkg.sv -----
// Shared types and constants for the pad and memory card serial port.
// Used by the datapath, controller, core and testbench files; depends on nothing.
`default_nettype none
package pmsp_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int BUF_DEPTH    = 256;

  localparam logic [2:0] K_WRITE  = 3'd0;
  localparam logic [2:0] K_READ   = 3'd1;
  localparam logic [2:0] K_CTRL   = 3'd2;
  localparam logic [2:0] K_STATUS = 3'd3;
  localparam logic [2:0] K_TICK   = 3'd4;

  localparam logic [1:0] CFG_CARD1 = 2'd0;
  localparam logic [1:0] CFG_CARD2 = 2'd1;
  localparam logic [1:0] CFG_DELAY = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] PPH_IDLE = 2'd0;
  localparam logic [1:0] PPH_CMD  = 2'd1;
  localparam logic [1:0] PPH_DATA = 2'd2;

  localparam logic [2:0] CPH_IDLE = 3'd0;
  localparam logic [2:0] CPH_CMD  = 3'd1;
  localparam logic [2:0] CPH_MSB  = 3'd2;
  localparam logic [2:0] CPH_LSB  = 3'd3;
  localparam logic [2:0] CPH_ACK  = 3'd4;
  localparam logic [2:0] CPH_DATA = 3'd5;

  localparam int SB_TXRDY = 0;
  localparam int SB_RXRDY = 1;
  localparam int SB_TXEMP = 2;
  localparam int SB_IRQ   = 9;
  localparam logic [9:0] STATUS_RST = 10'h005;

  localparam logic [15:0] DEV_MASK  = 16'h2002;
  localparam logic [15:0] DEV_ONE   = 16'h0002;
  localparam logic [15:0] DEV_TWO   = 16'h2002;
  localparam int          CB_SLOT2  = 13;
  localparam int          CB_ACKIRQ = 4;
  localparam int          CB_RESET  = 6;
  localparam int          CB_SELECT = 1;

  localparam logic [7:0] B_PAD_START  = 8'h01;
  localparam logic [7:0] B_CARD_START = 8'h81;
  localparam logic [7:0] B_READ       = 8'h52;
  localparam logic [7:0] B_WRITE      = 8'h57;
  localparam logic [7:0] B_ACK1       = 8'h5c;
  localparam logic [7:0] B_ACK2       = 8'h5d;
  localparam logic [7:0] B_END        = 8'h47;
  localparam logic [7:0] B_ID         = 8'h5a;
  localparam logic [7:0] B_NEWCARD    = 8'h08;
  localparam logic [7:0] B_FILL       = 8'hff;
  localparam logic [7:0] B_DIGITAL    = 8'h41;
  localparam logic [7:0] B_MODE_A     = 8'h43;
  localparam logic [7:0] B_MODE_B     = 8'h45;
  localparam logic [7:0] B_ANALOG     = 8'hf3;
  localparam logic [7:0] PAD_DEF_LEN  = 8'd34;
  localparam logic [15:0] DELAY_RST   = 16'd535;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_WAIT, ST_P1_WAIT, ST_SEQ, ST_FILL, ST_COMMIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {SQ_HELLO, SQ_RDHDR, SQ_WRHDR, SQ_RDTAIL} seq_t;

  typedef enum logic {DOP_FILL, DOP_COMMIT} dop_t;

  typedef struct packed {
    logic        buf_we;
    logic [7:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic [7:0]  buf_ra;
    logic        start;
    dop_t        op;
    logic        copy;
    logic        slot2;
    logic [15:0] sector;
    logic [7:0]  xinit;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] rd_data;
    logic [7:0] xsum;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/pmsp_if.sv -----
// Valid/ready channel interfaces for input beats, result beats and config writes.
// Standalone; no package dependency.
`default_nettype none
interface pmsp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] data_value;
  logic [7:0]  pad_reply;
  modport source (output valid, kind, data_value, pad_reply, input ready);
  modport sink (input valid, kind, data_value, pad_reply, output ready);
endinterface

interface pmsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [9:0] status_word;
  logic       irq_raise;
  modport source (output valid, read_data, status_word, irq_raise, input ready);
  modport sink (input valid, read_data, status_word, irq_raise, output ready);
endinterface

interface pmsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pmsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pmsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ----- hdl/pmsp_dpath.sv -----
// Datapath: reply buffer, card store, sector copy engine with checksum, reset sweep.
// Depends on pmsp_pkg and pmsp_ram.
`default_nettype none
module pmsp_dpath #(
  parameter int CARD_BYTES = 131072
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pmsp_pkg::dp_cmd_t cmd,
  output pmsp_pkg::dp_sts_t      sts
);
  localparam int CDEPTH = 2 * CARD_BYTES;
  localparam int CA     = $clog2(CDEPTH);
  localparam int KW     = $clog2(pmsp_pkg::SECTOR_BYTES);

  logic                 run_r, pv_r, clr_r, bvq_r, copy_r;
  logic [KW-1:0]        k_r, pk_r;
  pmsp_pkg::dop_t       op_r;
  logic [CA-1:0]        base_r, ca_r;
  logic [7:0]           x_r;
  logic [pmsp_pkg::BUF_DEPTH-1:0] vld_r;

  logic [7:0]    buf_ra, buf_wa, buf_wd, buf_q, card_q, bdata;
  logic          buf_we, card_we, fill_w;
  logic [CA-1:0] card_ra, card_wa;
  logic [7:0]    card_wd;
  logic [24:0]   base_w;

  always_comb begin
    if (run_r) begin
      buf_ra = (op_r == pmsp_pkg::DOP_FILL) ? 8'd4 + 8'(k_r) : 8'd1 + 8'(k_r);
    end else begin
      buf_ra = cmd.buf_ra;
    end
    card_ra = base_r + CA'(k_r);
    bdata   = bvq_r ? buf_q : 8'h00;
    fill_w  = pv_r && (op_r == pmsp_pkg::DOP_FILL) && copy_r;
    buf_we  = fill_w || cmd.buf_we;
    buf_wa  = fill_w ? 8'd4 + 8'(pk_r) : cmd.buf_wa;
    buf_wd  = fill_w ? card_q : cmd.buf_wd;
    card_we = clr_r || (pv_r && (op_r == pmsp_pkg::DOP_COMMIT));
    card_wa = clr_r ? ca_r : base_r + CA'(pk_r);
    card_wd = clr_r ? 8'h00 : bdata;
    base_w  = {2'b00, cmd.sector, 7'b0} + (cmd.slot2 ? 25'(CARD_BYTES) : 25'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pv_r  <= 1'b0;
      clr_r <= 1'b1;
      ca_r  <= '0;
      vld_r <= '0;
    end else begin
      if (cmd.start) begin
        run_r <= 1'b1;
      end else if (run_r && k_r == KW'(pmsp_pkg::SECTOR_BYTES - 1)) begin
        run_r <= 1'b0;
      end
      pv_r <= run_r;
      if (buf_we) vld_r[buf_wa] <= 1'b1;
      if (clr_r) begin
        ca_r <= ca_r + CA'(1);
        if (ca_r == CA'(CDEPTH - 1)) clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k_r    <= '0;
      op_r   <= cmd.op;
      copy_r <= cmd.copy;
      base_r <= base_w[CA-1:0];
      x_r    <= cmd.xinit;
    end else begin
      if (run_r) k_r <= k_r + KW'(1);
      if (pv_r && op_r == pmsp_pkg::DOP_FILL) x_r <= x_r ^ (copy_r ? card_q : bdata);
    end
    pk_r  <= k_r;
    bvq_r <= vld_r[buf_ra];
  end

  pmsp_ram #(.WIDTH(8), .DEPTH(pmsp_pkg::BUF_DEPTH)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_wa), .wdata(buf_wd), .raddr(buf_ra), .rdata(buf_q)
  );

  pmsp_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_card (
    .clk(clk), .we(card_we), .waddr(card_wa), .wdata(card_wd), .raddr(card_ra),
    .rdata(card_q)
  );

  assign sts.busy    = run_r || pv_r || clr_r;
  assign sts.rd_data = bdata;
  assign sts.xsum    = x_r;
endmodule
`default_nettype wire

// ----- hdl/pmsp_ctrl.sv -----
// Controller: protocol state, pad and card sequencing, countdown, config and result beats.
// Depends on pmsp_pkg and the channel interfaces; drives the datapath by command struct.
`default_nettype none
module pmsp_ctrl #(
  parameter int CARD_BYTES = 131072
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pmsp_in_if.sink                in_ch,
  pmsp_out_if.source             out_ch,
  pmsp_cfg_if.sink               cfg_ch,
  output pmsp_pkg::dp_cmd_t      cmd,
  input  wire pmsp_pkg::dp_sts_t sts
);
  localparam int SEC_CNT = CARD_BYTES / pmsp_pkg::SECTOR_BYTES;

  pmsp_pkg::state_t state_r, state_nxt;
  pmsp_pkg::seq_t   seq_r, seq_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [9:0]  status_r, status_nxt;
  logic [15:0] ctrl_r, ctrl_nxt;
  logic [1:0]  pad_ph_r, pad_ph_nxt;
  logic [2:0]  card_ph_r, card_ph_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  pos_r, pos_nxt, fin_r, fin_nxt, sh_r, sh_nxt, sl_r, sl_nxt;
  logic [1:0]  ncf_r, ncf_nxt;
  logic [15:0] cnt_r, cnt_nxt, dly_r, dly_nxt;
  logic        c1_r, c1_nxt, c2_r, c2_nxt;
  logic [7:0]  v_r, v_nxt, pad_r, pad_nxt, rd_r, rd_nxt;
  logic        irq_r, irq_nxt;
  logic        out_valid_r, out_valid_nxt, out_irq_r, out_irq_nxt;
  logic [7:0]  out_rd_r, out_rd_nxt;
  logic [9:0]  out_st_r, out_st_nxt;

  logic        in_ready, in_fire, dev1, dev2, dev_any, in_range, present, fresh, last;
  logic [15:0] arm;
  logic [7:0]  v, pad, np, b, nb;

  always_comb begin
    dev1     = (ctrl_r & pmsp_pkg::DEV_MASK) == pmsp_pkg::DEV_ONE;
    dev2     = (ctrl_r & pmsp_pkg::DEV_MASK) == pmsp_pkg::DEV_TWO;
    dev_any  = dev1 || dev2;
    in_range = {1'b0, sh_r, sl_r} < 17'(SEC_CNT);
    present  = ctrl_r[pmsp_pkg::CB_SLOT2] ? c2_r : c1_r;
    fresh    = ctrl_r[pmsp_pkg::CB_SLOT2] ? ncf_r[1] : ncf_r[0];
    arm      = (dly_r == 16'd0) ? 16'd1 : dly_r;
    in_ready = (state_r == pmsp_pkg::ST_IDLE) && !out_valid_r && !sts.busy;
    in_fire  = in_ch.valid && in_ready;
    v        = in_ch.data_value[7:0];
    pad      = in_ch.pad_reply;
    np       = pos_r + 8'd1;
    b        = dev_any ? pad_r : sts.rd_data;
    nb       = b;
    if (b == pmsp_pkg::B_DIGITAL && v_r == pmsp_pkg::B_MODE_A) nb = pmsp_pkg::B_MODE_A;
    if (b == pmsp_pkg::B_DIGITAL && v_r == pmsp_pkg::B_MODE_B) nb = pmsp_pkg::B_ANALOG;
    last = 1'b0;

    state_nxt = state_r;   seq_nxt = seq_r;       step_nxt = step_r;
    status_nxt = status_r; ctrl_nxt = ctrl_r;     pad_ph_nxt = pad_ph_r;
    card_ph_nxt = card_ph_r; op_nxt = op_r;       pos_nxt = pos_r;
    fin_nxt = fin_r;       sh_nxt = sh_r;         sl_nxt = sl_r;
    ncf_nxt = ncf_r;       cnt_nxt = cnt_r;       dly_nxt = dly_r;
    c1_nxt = c1_r;         c2_nxt = c2_r;         rd_nxt = rd_r;
    irq_nxt = irq_r;       out_valid_nxt = out_valid_r;
    out_rd_nxt = out_rd_r; out_st_nxt = out_st_r; out_irq_nxt = out_irq_r;
    v_nxt = in_fire ? v : v_r;
    pad_nxt = in_fire ? pad : pad_r;

    cmd        = '0;
    cmd.op     = pmsp_pkg::DOP_FILL;
    cmd.slot2  = dev2;
    cmd.sector = {sh_r, sl_r};
    cmd.xinit  = sh_r ^ sl_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      pmsp_pkg::ST_IDLE: begin
        if (in_fire) begin
          rd_nxt    = 8'h00;
          irq_nxt   = 1'b0;
          state_nxt = pmsp_pkg::ST_DONE;
          case (in_ch.kind)
            pmsp_pkg::K_TICK: begin
              if (cnt_r != 16'd0) begin
                cnt_nxt = cnt_r - 16'd1;
                if (cnt_r == 16'd1 && !status_r[pmsp_pkg::SB_IRQ]) begin
                  status_nxt[pmsp_pkg::SB_IRQ] = 1'b1;
                  irq_nxt = 1'b1;
                end
              end
            end
            pmsp_pkg::K_CTRL: begin
              ctrl_nxt = in_ch.data_value;
              ctrl_nxt[pmsp_pkg::CB_ACKIRQ] = 1'b0;
              if (in_ch.data_value[pmsp_pkg::CB_ACKIRQ]) status_nxt[pmsp_pkg::SB_IRQ] = 1'b0;
              if (in_ch.data_value[pmsp_pkg::CB_RESET] ||
                  !in_ch.data_value[pmsp_pkg::CB_SELECT]) begin
                pad_ph_nxt  = pmsp_pkg::PPH_IDLE;
                card_ph_nxt = pmsp_pkg::CPH_IDLE;
                pos_nxt     = 8'd0;
                status_nxt  = pmsp_pkg::STATUS_RST;
                cnt_nxt     = 16'd0;
              end
            end
            pmsp_pkg::K_READ: begin
              if (status_r[pmsp_pkg::SB_RXRDY]) begin
                cmd.buf_ra = pos_r;
                state_nxt  = pmsp_pkg::ST_RD_WAIT;
              end
            end
            pmsp_pkg::K_WRITE: begin
              if (pad_ph_r == pmsp_pkg::PPH_CMD) begin
                cnt_nxt = arm;
                if (v[6]) begin
                  pad_ph_nxt = pmsp_pkg::PPH_DATA;
                  pos_nxt    = 8'd1;
                  cmd.buf_ra = 8'd1;
                  state_nxt  = pmsp_pkg::ST_P1_WAIT;
                end else begin
                  pad_ph_nxt = pmsp_pkg::PPH_IDLE;
                end
              end else if (pad_ph_r == pmsp_pkg::PPH_DATA) begin
                pos_nxt = np;
                cmd.buf_we = dev_any;
                cmd.buf_wa = np;
                cmd.buf_wd = pad;
                if (np == fin_r) pad_ph_nxt = pmsp_pkg::PPH_IDLE;
                else cnt_nxt = arm;
              end else begin
                case (card_ph_r)
                  pmsp_pkg::CPH_CMD: begin
                    cnt_nxt = arm;
                    if (op_r != pmsp_pkg::OP_NONE) begin
                      pos_nxt = np;
                    end else begin
                      pos_nxt = 8'd1;
                      if (v == pmsp_pkg::B_READ) op_nxt = pmsp_pkg::OP_READ;
                      else if (v == pmsp_pkg::B_WRITE) op_nxt = pmsp_pkg::OP_WRITE;
                      else card_ph_nxt = pmsp_pkg::CPH_IDLE;
                    end
                  end
                  pmsp_pkg::CPH_MSB: begin
                    cnt_nxt = arm;
                    sh_nxt = v;
                    cmd.buf_we = 1'b1;
                    cmd.buf_wa = 8'd0;
                    cmd.buf_wd = 8'h00;
                    pos_nxt = 8'd0;
                    fin_nxt = 8'd1;
                    card_ph_nxt = pmsp_pkg::CPH_LSB;
                  end
                  pmsp_pkg::CPH_LSB: begin
                    cnt_nxt = arm;
                    sl_nxt = v;
                    cmd.buf_we = 1'b1;
                    cmd.buf_wa = 8'd0;
                    cmd.buf_wd = sh_r;
                    pos_nxt = 8'd0;
                    fin_nxt = 8'd1;
                    card_ph_nxt = pmsp_pkg::CPH_ACK;
                  end
                  pmsp_pkg::CPH_ACK: begin
                    cnt_nxt = arm;
                    pos_nxt = 8'd0;
                    step_nxt = 3'd0;
                    if (op_r == pmsp_pkg::OP_READ) begin
                      seq_nxt = pmsp_pkg::SQ_RDHDR;
                      fin_nxt = 8'(pmsp_pkg::SECTOR_BYTES + 5);
                      state_nxt = pmsp_pkg::ST_SEQ;
                    end else if (op_r == pmsp_pkg::OP_WRITE) begin
                      seq_nxt = pmsp_pkg::SQ_WRHDR;
                      fin_nxt = 8'(pmsp_pkg::SECTOR_BYTES + 3);
                      state_nxt = pmsp_pkg::ST_SEQ;
                    end
                    card_ph_nxt = pmsp_pkg::CPH_DATA;
                  end
                  pmsp_pkg::CPH_DATA: begin
                    pos_nxt = np;
                    if ((op_r == pmsp_pkg::OP_READ && np == 8'(pmsp_pkg::SECTOR_BYTES + 4)) ||
                        (op_r == pmsp_pkg::OP_WRITE && np == 8'(pmsp_pkg::SECTOR_BYTES + 1))) begin
                      ncf_nxt = ctrl_r[pmsp_pkg::CB_SLOT2] ? (ncf_r & 2'b01) : (ncf_r & 2'b10);
                    end
                    if (op_r == pmsp_pkg::OP_WRITE && np < 8'(pmsp_pkg::SECTOR_BYTES)) begin
                      cmd.buf_we = 1'b1;
                      cmd.buf_wa = np + 8'd1;
                      cmd.buf_wd = v;
                    end
                    cnt_nxt = arm;
                  end
                  default: begin
                    status_nxt[pmsp_pkg::SB_RXRDY] = 1'b1;
                    pos_nxt = 8'd0;
                    if (v == pmsp_pkg::B_PAD_START) begin
                      cmd.buf_we = dev_any;
                      cmd.buf_wa = 8'd0;
                      cmd.buf_wd = pad;
                      fin_nxt = 8'd2;
                      pad_ph_nxt = pmsp_pkg::PPH_CMD;
                      cnt_nxt = arm;
                    end else if (v == pmsp_pkg::B_CARD_START && present) begin
                      fin_nxt = 8'd3;
                      card_ph_nxt = pmsp_pkg::CPH_CMD;
                      op_nxt = pmsp_pkg::OP_NONE;
                      cnt_nxt = arm;
                      seq_nxt = pmsp_pkg::SQ_HELLO;
                      step_nxt = 3'd0;
                      state_nxt = pmsp_pkg::ST_SEQ;
                    end else begin
                      cmd.buf_we = 1'b1;
                      cmd.buf_wa = 8'd0;
                      cmd.buf_wd = pmsp_pkg::B_FILL;
                      fin_nxt = 8'd0;
                    end
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
      pmsp_pkg::ST_RD_WAIT: begin
        rd_nxt = sts.rd_data;
        state_nxt = pmsp_pkg::ST_DONE;
        if (pos_r == fin_r) begin
          status_nxt[pmsp_pkg::SB_RXRDY] = 1'b0;
          if (card_ph_r == pmsp_pkg::CPH_DATA) begin
            card_ph_nxt = pmsp_pkg::CPH_IDLE;
            if (op_r == pmsp_pkg::OP_WRITE && dev_any && in_range) begin
              cmd.start = 1'b1;
              cmd.op    = pmsp_pkg::DOP_COMMIT;
              cmd.copy  = 1'b1;
              state_nxt = pmsp_pkg::ST_COMMIT;
            end
          end
          if (pad_ph_r == pmsp_pkg::PPH_DATA) pad_ph_nxt = pmsp_pkg::PPH_IDLE;
          if (card_ph_r == pmsp_pkg::CPH_CMD) begin
            card_ph_nxt = pmsp_pkg::CPH_MSB;
            status_nxt[pmsp_pkg::SB_RXRDY] = 1'b1;
          end
        end
      end
      pmsp_pkg::ST_P1_WAIT: begin
        fin_nxt = (b[3:0] != 4'd0) ? 8'd2 + {3'b000, b[3:0], 1'b0} : pmsp_pkg::PAD_DEF_LEN;
        cmd.buf_we = 1'b1;
        cmd.buf_wa = 8'd1;
        cmd.buf_wd = nb;
        state_nxt = pmsp_pkg::ST_DONE;
      end
      pmsp_pkg::ST_SEQ: begin
        cmd.buf_we = 1'b1;
        step_nxt = step_r + 3'd1;
        case (seq_r)
          pmsp_pkg::SQ_HELLO: begin
            cmd.buf_wa = 8'(step_r);
            case (step_r)
              3'd0:    cmd.buf_wd = pmsp_pkg::B_FILL;
              3'd1:    cmd.buf_wd = fresh ? pmsp_pkg::B_NEWCARD : 8'h00;
              3'd2:    cmd.buf_wd = pmsp_pkg::B_ID;
              default: cmd.buf_wd = pmsp_pkg::B_ACK2;
            endcase
            last = step_r == 3'd3;
          end
          pmsp_pkg::SQ_RDHDR: begin
            cmd.buf_wa = 8'(step_r);
            case (step_r)
              3'd0:    cmd.buf_wd = pmsp_pkg::B_ACK1;
              3'd1:    cmd.buf_wd = pmsp_pkg::B_ACK2;
              3'd2:    cmd.buf_wd = sh_r;
              default: cmd.buf_wd = sl_r;
            endcase
            last = step_r == 3'd3;
          end
          pmsp_pkg::SQ_WRHDR: begin
            case (step_r)
              3'd0: begin
                cmd.buf_wa = 8'd0;
                cmd.buf_wd = sl_r;
              end
              3'd1: begin
                cmd.buf_wa = 8'd1;
                cmd.buf_wd = v_r;
              end
              3'd2: begin
                cmd.buf_wa = 8'(pmsp_pkg::SECTOR_BYTES + 1);
                cmd.buf_wd = pmsp_pkg::B_ACK1;
              end
              3'd3: begin
                cmd.buf_wa = 8'(pmsp_pkg::SECTOR_BYTES + 2);
                cmd.buf_wd = pmsp_pkg::B_ACK2;
              end
              default: begin
                cmd.buf_wa = 8'(pmsp_pkg::SECTOR_BYTES + 3);
                cmd.buf_wd = pmsp_pkg::B_END;
              end
            endcase
            last = step_r == 3'd4;
          end
          default: begin
            if (step_r == 3'd0) begin
              cmd.buf_wa = 8'(pmsp_pkg::SECTOR_BYTES + 4);
              cmd.buf_wd = sts.xsum;
            end else begin
              cmd.buf_wa = 8'(pmsp_pkg::SECTOR_BYTES + 5);
              cmd.buf_wd = pmsp_pkg::B_END;
            end
            last = step_r == 3'd1;
          end
        endcase
        if (last) begin
          if (seq_r == pmsp_pkg::SQ_RDHDR) begin
            cmd.start = 1'b1;
            cmd.copy  = dev_any && in_range;
            state_nxt = pmsp_pkg::ST_FILL;
          end else begin
            state_nxt = pmsp_pkg::ST_DONE;
          end
        end
      end
      pmsp_pkg::ST_FILL: begin
        if (!sts.busy) begin
          seq_nxt = pmsp_pkg::SQ_RDTAIL;
          step_nxt = 3'd0;
          state_nxt = pmsp_pkg::ST_SEQ;
        end
      end
      pmsp_pkg::ST_COMMIT: begin
        if (!sts.busy) state_nxt = pmsp_pkg::ST_DONE;
      end
      pmsp_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_rd_nxt = rd_r;
        out_st_nxt = status_r;
        out_irq_nxt = irq_r;
        state_nxt = pmsp_pkg::ST_IDLE;
      end
      default: state_nxt = pmsp_pkg::ST_IDLE;
    endcase

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pmsp_pkg::CFG_CARD1: begin
          if (cfg_ch.data[0] && !c1_r) ncf_nxt[0] = 1'b1;
          c1_nxt = cfg_ch.data[0];
        end
        pmsp_pkg::CFG_CARD2: begin
          if (cfg_ch.data[0] && !c2_r) ncf_nxt[1] = 1'b1;
          c2_nxt = cfg_ch.data[0];
        end
        pmsp_pkg::CFG_DELAY: dly_nxt = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmsp_pkg::ST_IDLE;
      status_r    <= pmsp_pkg::STATUS_RST;
      ctrl_r      <= '0;
      pad_ph_r    <= pmsp_pkg::PPH_IDLE;
      card_ph_r   <= pmsp_pkg::CPH_IDLE;
      op_r        <= pmsp_pkg::OP_NONE;
      pos_r       <= '0;
      fin_r       <= '0;
      sh_r        <= '0;
      sl_r        <= '0;
      ncf_r       <= 2'b11;
      cnt_r       <= '0;
      dly_r       <= pmsp_pkg::DELAY_RST;
      c1_r        <= 1'b0;
      c2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      ctrl_r      <= ctrl_nxt;
      pad_ph_r    <= pad_ph_nxt;
      card_ph_r   <= card_ph_nxt;
      op_r        <= op_nxt;
      pos_r       <= pos_nxt;
      fin_r       <= fin_nxt;
      sh_r        <= sh_nxt;
      sl_r        <= sl_nxt;
      ncf_r       <= ncf_nxt;
      cnt_r       <= cnt_nxt;
      dly_r       <= dly_nxt;
      c1_r        <= c1_nxt;
      c2_r        <= c2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r     <= seq_nxt;
    step_r    <= step_nxt;
    v_r       <= v_nxt;
    pad_r     <= pad_nxt;
    rd_r      <= rd_nxt;
    irq_r     <= irq_nxt;
    out_rd_r  <= out_rd_nxt;
    out_st_r  <= out_st_nxt;
    out_irq_r <= out_irq_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_rd_r;
  assign out_ch.status_word = out_st_r;
  assign out_ch.irq_raise   = out_irq_r;
endmodule
`default_nettype wire

// ----- hdl/pad_memcard_serial_port_core.sv -----
// Flow: tick, control and status beats go from acceptance to DONE, which registers the result;
// a data read passes RD_WAIT first; a card sector read runs the header, a 128-byte copy with
// checksum through the card store read port and the tail, a write commit a copy into the store.
// One beat is in flight at a time; the next is taken once the result has been delivered.
// Reset: synchronous, active low; then a sweep zeroes all 2*CARD_BYTES bytes of the card store
// while no input beat is accepted (config writes are taken throughout).
`default_nettype none
module pad_memcard_serial_port_core #(
  parameter int CARD_BYTES = 131072
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pmsp_in_if.sink    in_ch,
  pmsp_out_if.source out_ch,
  pmsp_cfg_if.sink   cfg_ch
);
  pmsp_pkg::dp_cmd_t dp_cmd;
  pmsp_pkg::dp_sts_t dp_sts;

  pmsp_ctrl #(.CARD_BYTES(CARD_BYTES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .cmd(dp_cmd), .sts(dp_sts)
  );

  pmsp_dpath #(.CARD_BYTES(CARD_BYTES)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .sts(dp_sts)
  );

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !dp_sts.busy)
    else $error("beat accepted while datapath busy");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.start |-> !dp_sts.busy)
    else $error("copy started while datapath busy");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !out_ch.valid)
    else $error("result shown in cycle after acceptance");
`endif
endmodule
`default_nettype wire

// ----- tb/pmsp_checker.sv -----
// Checker for the pad and memory card serial port: watches the config, input and result
// channels, keeps its own copy of the port state and compares every result beat.
// Depends on pmsp_pkg and the channel interfaces in pmsp_if.sv.
`default_nettype none
module pmsp_checker #(
  parameter int CARD_BYTES = 131072
) (
  input wire logic clk,
  input wire logic rst_n,
  pmsp_in_if       in_ch,
  pmsp_out_if      out_ch,
  pmsp_cfg_if      cfg_ch,
  output int       fails,
  output int       pending
);
  import pmsp_pkg::*;

  typedef struct {
    logic [7:0] rd;
    logic [9:0] status;
    logic       irq;
  } port_result_t;

  port_result_t result_q[$];

  logic        card1_in, card2_in;
  logic [15:0] delay_reg;
  logic [7:0]  rbuf[BUF_DEPTH];
  logic [7:0]  cstore[2*CARD_BYTES];
  logic [15:0] status_r, ctrl_r;
  logic [1:0]  pph;
  logic [2:0]  cph;
  logic [1:0]  cop;
  logic [7:0]  pos, fin, sec_hi, sec_lo;
  logic [1:0]  fresh;
  logic [15:0] countdown;

  function automatic int sel_dev();
    if ((ctrl_r & DEV_MASK) == DEV_ONE) return 1;
    if ((ctrl_r & DEV_MASK) == DEV_TWO) return 2;
    return 0;
  endfunction

  function automatic void arm_countdown();
    countdown = (delay_reg != 0) ? delay_reg : 16'd1;
  endfunction

  function automatic int unsigned sector_len(output int unsigned addr);
    addr = {sec_hi, sec_lo} * SECTOR_BYTES;
    if (addr >= CARD_BYTES) return 0;
    if (CARD_BYTES - addr < SECTOR_BYTES) return CARD_BYTES - addr;
    return SECTOR_BYTES;
  endfunction

  function automatic void sector_move(int dev, bit to_card);
    int unsigned addr, n, base;
    n = sector_len(addr);
    base = (dev - 1) * CARD_BYTES + addr;
    for (int unsigned i = 0; i < n; i++) begin
      if (to_card) cstore[base + i] = rbuf[1 + i];
      else rbuf[4 + i] = cstore[base + i];
    end
  endfunction

  function automatic void byte_write(logic [7:0] v, logic [7:0] pad);
    int dev;
    logic [7:0] x;
    logic slot2;
    dev = sel_dev();
    if (pph == PPH_CMD) begin
      arm_countdown();
      if (v[6]) begin
        pph = PPH_DATA;
        pos = 1;
        if (dev != 0) rbuf[1] = pad;
        fin = (rbuf[1][3:0] != 0) ? 8'(2 + rbuf[1][3:0] * 2) : PAD_DEF_LEN;
        if (rbuf[1] == B_DIGITAL) begin
          if (v == B_MODE_A) rbuf[1] = B_MODE_A;
          else if (v == B_MODE_B) rbuf[1] = B_ANALOG;
        end
      end else begin
        pph = PPH_IDLE;
      end
      return;
    end
    if (pph == PPH_DATA) begin
      pos++;
      if (dev != 0) rbuf[pos] = pad;
      if (pos == fin) begin
        pph = PPH_IDLE;
        return;
      end
      arm_countdown();
      return;
    end
    case (cph)
      CPH_CMD: begin
        arm_countdown();
        if (cop != OP_NONE) begin
          pos++;
          return;
        end
        pos = 1;
        if (v == B_READ) cop = OP_READ;
        else if (v == B_WRITE) cop = OP_WRITE;
        else cph = CPH_IDLE;
        return;
      end
      CPH_MSB: begin
        arm_countdown();
        sec_hi = v;
        rbuf[0] = 0;
        pos = 0;
        fin = 1;
        cph = CPH_LSB;
        return;
      end
      CPH_LSB: begin
        arm_countdown();
        sec_lo = v;
        rbuf[0] = sec_hi;
        pos = 0;
        fin = 1;
        cph = CPH_ACK;
        return;
      end
      CPH_ACK: begin
        arm_countdown();
        pos = 0;
        if (cop == OP_READ) begin
          rbuf[0] = B_ACK1;
          rbuf[1] = B_ACK2;
          rbuf[2] = sec_hi;
          rbuf[3] = sec_lo;
          if (dev != 0) sector_move(dev, 1'b0);
          x = 0;
          for (int i = 2; i < SECTOR_BYTES + 4; i++) x ^= rbuf[i];
          rbuf[SECTOR_BYTES + 4] = x;
          rbuf[SECTOR_BYTES + 5] = B_END;
          fin = 8'(SECTOR_BYTES + 5);
        end else if (cop == OP_WRITE) begin
          rbuf[0] = sec_lo;
          rbuf[1] = v;
          rbuf[SECTOR_BYTES + 1] = B_ACK1;
          rbuf[SECTOR_BYTES + 2] = B_ACK2;
          rbuf[SECTOR_BYTES + 3] = B_END;
          fin = 8'(SECTOR_BYTES + 3);
        end
        cph = CPH_DATA;
        return;
      end
      CPH_DATA: begin
        pos++;
        if ((cop == OP_READ && pos == SECTOR_BYTES + 4) ||
            (cop == OP_WRITE && pos == SECTOR_BYTES + 1)) begin
          if (ctrl_r[CB_SLOT2]) fresh &= 2'b01;
          else fresh &= 2'b10;
        end
        if (cop == OP_WRITE && pos < SECTOR_BYTES) rbuf[pos + 1] = v;
        arm_countdown();
        return;
      end
      default: ;
    endcase
    if (v == B_PAD_START) begin
      status_r[SB_RXRDY] = 1'b1;
      if (dev != 0) rbuf[0] = pad;
      fin = 2;
      pos = 0;
      pph = PPH_CMD;
      arm_countdown();
      return;
    end
    slot2 = ctrl_r[CB_SLOT2];
    if (v == B_CARD_START && (slot2 ? card2_in : card1_in)) begin
      rbuf[0] = B_FILL;
      rbuf[1] = fresh[slot2] ? B_NEWCARD : 8'h00;
      rbuf[2] = B_ID;
      rbuf[3] = B_ACK2;
      status_r[SB_RXRDY] = 1'b1;
      pos = 0;
      fin = 3;
      cph = CPH_CMD;
      cop = OP_NONE;
      arm_countdown();
      return;
    end
    status_r[SB_RXRDY] = 1'b1;
    rbuf[0] = B_FILL;
    pos = 0;
    fin = 0;
  endfunction

  function automatic logic [7:0] byte_read();
    logic [7:0] r;
    int dev;
    if (!status_r[SB_RXRDY]) return 8'h00;
    r = rbuf[pos];
    if (pos == fin) begin
      status_r[SB_RXRDY] = 1'b0;
      if (cph == CPH_DATA) begin
        cph = CPH_IDLE;
        if (cop == OP_WRITE) begin
          dev = sel_dev();
          if (dev != 0) sector_move(dev, 1'b1);
        end
      end
      if (pph == PPH_DATA) pph = PPH_IDLE;
      if (cph == CPH_CMD) begin
        cph = CPH_MSB;
        status_r[SB_RXRDY] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void control_write(logic [15:0] v);
    ctrl_r = v;
    ctrl_r[CB_ACKIRQ] = 1'b0;
    if (v[CB_ACKIRQ]) status_r[SB_IRQ] = 1'b0;
    if (ctrl_r[CB_RESET] || !ctrl_r[CB_SELECT]) begin
      pph = PPH_IDLE;
      cph = CPH_IDLE;
      pos = 0;
      status_r = 16'(STATUS_RST);
      countdown = 0;
    end
  endfunction

  function automatic port_result_t port_step(logic [2:0] kind, logic [15:0] dv,
                                             logic [7:0] pad);
    port_result_t res;
    res.rd = 0;
    res.irq = 0;
    case (kind)
      K_WRITE: byte_write(dv[7:0], pad);
      K_READ:  res.rd = byte_read();
      K_CTRL:  control_write(dv);
      K_TICK: begin
        if (countdown != 0) begin
          countdown--;
          if (countdown == 0 && !status_r[SB_IRQ]) begin
            status_r[SB_IRQ] = 1'b1;
            res.irq = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.status = status_r[9:0];
    return res;
  endfunction

  always @(posedge clk) begin
    port_result_t got, want;
    if (!rst_n) begin
      card1_in = 0;
      card2_in = 0;
      delay_reg = DELAY_RST;
      for (int i = 0; i < BUF_DEPTH; i++) rbuf[i] = 0;
      for (int i = 0; i < 2 * CARD_BYTES; i++) cstore[i] = 0;
      status_r = 16'(STATUS_RST);
      ctrl_r = 0;
      pph = PPH_IDLE;
      cph = CPH_IDLE;
      cop = OP_NONE;
      pos = 0;
      fin = 0;
      sec_hi = 0;
      sec_lo = 0;
      fresh = 2'b11;
      countdown = 0;
      result_q.delete();
      fails <= 0;
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_CARD1: begin
            if (cfg_ch.data[0] && !card1_in) fresh[0] = 1'b1;
            card1_in = cfg_ch.data[0];
          end
          CFG_CARD2: begin
            if (cfg_ch.data[0] && !card2_in) fresh[1] = 1'b1;
            card2_in = cfg_ch.data[0];
          end
          CFG_DELAY: delay_reg = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(port_step(in_ch.kind, in_ch.data_value, in_ch.pad_reply));
      if (out_ch.valid && out_ch.ready) begin
        got.rd = out_ch.read_data;
        got.status = out_ch.status_word;
        got.irq = out_ch.irq_raise;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails <= fails + 1;
        end else begin
          want = result_q.pop_front();
          if (got.rd !== want.rd) $error("read_data: expected %h, got %h", want.rd, got.rd);
          if (got.status !== want.status)
            $error("status_word: expected %h, got %h", want.status, got.status);
          if (got.irq !== want.irq)
            $error("irq_raise: expected %b, got %b", want.irq, got.irq);
          if (got.rd !== want.rd || got.status !== want.status || got.irq !== want.irq)
            fails <= fails + 1;
        end
      end
      pending <= result_q.size();
    end
  end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the serial port testbench: clock, reset, config writes, directed and random
// pad and card traffic with random stalls on both channels, and the verdict.
// Depends on pmsp_pkg, pmsp_if.sv, the port core and pmsp_checker.
`default_nettype none
module testbench;
  import pmsp_pkg::*;

  localparam int CB = 8192;
  localparam int LIMIT = 2000000;

  logic clk, rst_n;
  int   fails, pending, cycles, beats, sectors, polls;
  int   tx_idle, rx_idle;

  pmsp_in_if  in_ch();
  pmsp_out_if out_ch();
  pmsp_cfg_if cfg_ch();

  pad_memcard_serial_port_core #(.CARD_BYTES(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pmsp_checker #(.CARD_BYTES(CB)) chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle);

  task automatic send_beat(logic [2:0] kind, logic [15:0] dv, logic [7:0] pad);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.kind = kind;
    in_ch.data_value = dv;
    in_ch.pad_reply = pad;
    in_ch.valid = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats++;
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic maybe_tick();
    if ($urandom_range(99) < 20) send_beat(K_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic card_sector(bit slot2, bit wr);
    logic [7:0] hi, lo, opb;
    int n;
    hi = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
    lo = 8'($urandom_range(0, 70));
    opb = wr ? B_WRITE : B_READ;
    if ($urandom_range(15) == 0) opb = 8'($urandom);
    send_beat(K_CTRL, (slot2 ? DEV_TWO : DEV_ONE) | ($urandom_range(1) ? 16'h0010 : 16'h0),
              8'($urandom));
    send_beat(K_WRITE, 16'(B_CARD_START), 8'($urandom));
    send_beat(K_READ, 16'($urandom), 8'($urandom));
    send_beat(K_WRITE, 16'(opb), 8'($urandom));
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 0, 8'($urandom));
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 0, 8'($urandom));
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 16'(hi), 8'($urandom));
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 16'(lo), 8'($urandom));
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 16'($urandom), 8'($urandom));
    send_beat(K_READ, 0, 0);
    n = wr ? SECTOR_BYTES + 3 : SECTOR_BYTES + 5;
    for (int i = 0; i < n; i++) begin
      send_beat(K_WRITE, 16'($urandom), 8'($urandom));
      if ($urandom_range(99) < 25) send_beat(K_READ, 0, 0);
      maybe_tick();
    end
    send_beat(K_READ, 0, 0);
    sectors++;
  endtask

  task automatic pad_poll();
    logic [7:0] mode;
    send_beat(K_CTRL, $urandom_range(1) ? DEV_TWO : DEV_ONE, 0);
    send_beat(K_WRITE, 16'(B_PAD_START), 8'($urandom));
    send_beat(K_READ, 0, 0);
    case ($urandom_range(3))
      0: mode = B_MODE_A;
      1: mode = B_MODE_B;
      2: mode = 8'h42;
      default: mode = 8'($urandom);
    endcase
    send_beat(K_WRITE, 16'(mode), $urandom_range(1) ? B_DIGITAL : 8'($urandom));
    send_beat(K_READ, 0, 0);
    for (int i = 0; i < 36; i++) begin
      send_beat(K_WRITE, 16'($urandom), 8'($urandom));
      send_beat(K_READ, 0, 0);
      maybe_tick();
    end
    polls++;
  endtask

  task automatic random_phase(int target);
    int stop_at, pick;
    stop_at = beats + target;
    while (beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) card_sector($urandom_range(1), $urandom_range(1));
      else if (pick < 30) pad_poll();
      else if (pick < 60) send_beat(K_TICK, 16'($urandom), 8'($urandom));
      else send_beat(3'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_n = 0;
    cycles = 0;
    beats = 0;
    sectors = 0;
    polls = 0;
    tx_idle = 8;
    rx_idle = 81;
    in_ch.valid = 0;
    in_ch.kind = 0;
    in_ch.data_value = 0;
    in_ch.pad_reply = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    write_reg(CFG_DELAY, 16'd0);
    send_beat(K_STATUS, 16'hffff, 8'hff);
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 16'(B_CARD_START), 8'h00);
    send_beat(K_TICK, 0, 0);
    send_beat(K_CTRL, DEV_ONE, 0);
    send_beat(K_WRITE, 16'(B_CARD_START), 8'hff);
    send_beat(K_READ, 0, 0);
    send_beat(K_WRITE, 16'(B_PAD_START), 8'hff);
    send_beat(K_TICK, 0, 0);
    send_beat(K_TICK, 0, 0);
    send_beat(K_CTRL, 16'hffff, 0);
    send_beat(K_CTRL, 16'h0012, 0);
    send_beat(3'd5, 16'hffff, 8'hff);
    send_beat(3'd6, 16'h0000, 8'h00);
    send_beat(3'd7, 16'haaaa, 8'h55);
    send_beat(K_CTRL, 16'h0000, 0);
    send_beat(K_STATUS, 0, 0);
    drain();

    write_reg(CFG_CARD1, 1);
    write_reg(CFG_CARD2, 1);
    write_reg(CFG_DELAY, 16'd2);
    random_phase(90);
    drain();

    tx_idle = 81;
    rx_idle = 8;
    write_reg(CFG_CARD1, 0);
    write_reg(CFG_DELAY, 16'd1);
    random_phase(90);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    write_reg(CFG_CARD1, 1);
    write_reg(CFG_CARD2, 0);
    write_reg(CFG_DELAY, 16'd65535);
    random_phase(25);
    drain();
    write_reg(CFG_CARD2, 1);
    write_reg(CFG_DELAY, 16'd3);
    random_phase(60);
    drain();

    $display("Run covered %0d beats: %0d card sector transfers and %0d pad polls,",
             beats, sectors, polls);
    $display("with card slots swapped in and out and byte delays from zero to maximum.");
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
